// ===== sv/f2cf_pkg.sv =====
// Package for the float32 to custom float converter.
// Holds register addresses and source format constants; no dependencies.
package f2cf_pkg;
  localparam logic [7:0]  SrcBias    = 8'd127;
  localparam logic [7:0]  SrcExpOnes = 8'hFF;
  localparam logic [0:0]  RegExpW    = 1'b0;
  localparam logic [0:0]  RegManW    = 1'b1;
  localparam logic [4:0]  ExpWReset  = 5'd5;
  localparam logic [5:0]  ManWReset  = 6'd10;
endpackage

// ===== sv/f2cf_cfg.sv =====
// Configuration registers with APB-style write/read access.
// Depends on f2cf_pkg.
module f2cf_cfg import f2cf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  exp_w_o,
  output logic [5:0]  man_w_o
);
  logic [4:0] exp_w_q;
  logic [5:0] man_w_q;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_w_q <= ExpWReset;
      man_w_q <= ManWReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegExpW) exp_w_q <= pwdata[4:0];
      else man_w_q <= pwdata[5:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegExpW) prdata = {27'd0, exp_w_q};
    else prdata = {26'd0, man_w_q};
  end

  assign exp_w_o = exp_w_q;
  assign man_w_o = man_w_q;
endmodule

// ===== sv/f2cf_conv.sv =====
// Combinational conversion from float32 to the configured format.
// Depends on f2cf_pkg.
module f2cf_conv import f2cf_pkg::*; (
  input  logic [31:0] src_i,
  input  logic [4:0]  exp_w_i,
  input  logic [5:0]  man_w_i,
  output logic [63:0] dst_o
);
  logic [5:0]  m;
  logic [4:0]  e;
  logic [16:0] bias, emax;
  logic [7:0]  e8;
  logic [22:0] f23;
  logic [23:0] sig;
  logic [4:0]  p;
  logic signed [18:0] u, d, k;
  logic [63:0] sgn, inf, man, msk;
  logic [63:0] frac64;

  always_comb begin
    m = man_w_i;
    if (m < 6'd1) m = 6'd1;
    if (m > 6'd62) m = 6'd62;
    e = exp_w_i;
    if (e < 5'd1) e = 5'd1;
    if (e > 5'd16) e = 5'd16;
    if ({1'b0, e} > 6'd63 - m) e = 5'(6'd63 - m);
    bias = (17'd1 << (e - 5'd1)) - 17'd1;
    emax = (17'd1 << e) - 17'd1;
    sgn = 64'(src_i[31]) << (7'(e) + 7'(m));
    inf = sgn | (64'(emax) << m);
    e8 = src_i[30:23];
    f23 = src_i[22:0];
    p = 5'd0;
    for (int i = 1; i < 23; i++) if (f23[i]) p = 5'(i);
    if (e8 != 8'd0) begin
      sig = {1'b1, f23};
      u = 19'(e8) - 19'(SrcBias);
    end else begin
      sig = 24'({1'b0, f23} << (5'd23 - p));
      u = 19'(p) - 19'sd149;
    end
    d = u + 19'(bias);
    k = d - 19'sd24 + 19'(m);
    frac64 = 64'(sig[22:0]);
    msk = (64'd1 << m) - 64'd1;
    if (k >= 0) man = 64'(sig) << k[5:0];
    else if (-k >= 19'sd64) man = 64'd0;
    else man = 64'(sig) >> 6'(-k);
    if (e8 == SrcExpOnes) dst_o = inf;
    else if (e8 == 8'd0 && f23 == 23'd0) dst_o = sgn;
    else if (d >= $signed(19'(emax))) dst_o = inf;
    else if (d >= 19'sd1) begin
      if (m >= 6'd23) dst_o = sgn | (64'(d[16:0]) << m) | (frac64 << (m - 6'd23));
      else dst_o = sgn | (64'(d[16:0]) << m) | (frac64 >> (6'd23 - m));
    end else dst_o = sgn | (man & msk);
  end
endmodule

// ===== sv/float32_to_custom_float_core.sv =====
// Top level of the float32 to custom float converter.
// Depends on f2cf_pkg, f2cf_cfg, f2cf_conv.
//
// Usage:
//   Pulse start_i with source_word_i while busy_o is low; busy_o is always
//   low, so a word is taken every cycle. The source word is registered,
//   converted by one combinational pass, and the result is registered.
//   target_word_o is valid for one cycle with done_o high once the word has
//   passed the source and result registers. Throughput: one word per cycle.
//   The receiver cannot stall; every result shows for exactly one cycle.
//   Widths are set over the APB port: exponent_width at 0x0, mantissa_width
//   at 0x4, written by the user only when no word is in flight (not checked).
//   Reset clears the pipeline valid bits and sets the widths to 5 and 10.
module float32_to_custom_float_core import f2cf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] source_word_i,
  output logic        done_o,
  output logic [63:0] target_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0]  exp_w;
  logic [5:0]  man_w;
  logic        in_vld_q, out_vld_q;
  logic [31:0] src_q;
  logic [63:0] res_d, res_q;

  f2cf_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .exp_w_o(exp_w), .man_w_o(man_w)
  );

  f2cf_conv u_conv (.src_i(src_q), .exp_w_i(exp_w), .man_w_i(man_w), .dst_o(res_d));

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) src_q <= source_word_i;
    if (in_vld_q) res_q <= res_d;
  end

  assign done_o = out_vld_q;
  assign target_word_o = res_q;
endmodule
